[hw/rtl/stbs_pkg.sv]
// Shared types and codes for the sorted table binary search block.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package stbs_pkg;

  // Width of every input field and of the result position
  localparam int FIELD_W = 8;

  // Item kind carried on s_tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMPTY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // store the write item's entry
    logic load;      // capture a search item and probe its first midpoint
    logic step;      // narrow the range and probe the next midpoint
    logic post;      // load the result register
    logic post_hit;  // result is a hit at the current midpoint
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_empty;  // incoming search range is empty
    logic hit;         // probed entry equals the target
    logic next_empty;  // range is empty after this step
    logic out_free;    // result register can take a word this cycle
  } dp_status_t;

endpackage

[hw/rtl/stbs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/stbs_ctrl.sv]
// Controller state machine for the binary search block.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   item_cmd,
  input  stbs_pkg::dp_status_t   status,
  output stbs_pkg::ctrl_cmd_t    cmd
);

  stbs_pkg::state_t state, state_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    accept     = 1'b0;
    case (state)
      stbs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        accept   = s_tvalid;
        if (accept && item_cmd == stbs_pkg::CMD_WRITE) begin
          cmd.wr_en = 1'b1;
        end else if (accept) begin
          cmd.load   = 1'b1;
          state_next = status.init_empty ? stbs_pkg::ST_EMPTY : stbs_pkg::ST_SEARCH;
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (status.hit || status.next_empty) begin
          // hold the probe until the result register frees up
          if (status.out_free) begin
            cmd.post     = 1'b1;
            cmd.post_hit = status.hit;
            state_next   = stbs_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      stbs_pkg::ST_EMPTY: begin
        if (status.out_free) begin
          cmd.post   = 1'b1;
          state_next = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/stbs_dpath.sv]
// Datapath for the binary search block: range registers, midpoint, table RAM,
// result register. Depends on stbs_pkg and stbs_ram.
`timescale 1ns / 1ps

module stbs_dpath #(
  parameter int TABLE_DEPTH = 256,
  parameter int ENTRY_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [stbs_pkg::FIELD_W-1:0]   entry_index,
  input  logic [stbs_pkg::FIELD_W-1:0]   entry_value,
  input  logic [stbs_pkg::FIELD_W-1:0]   target,
  input  logic [stbs_pkg::FIELD_W-1:0]   low_index,
  input  logic [stbs_pkg::FIELD_W-1:0]   high_index,
  input  stbs_pkg::ctrl_cmd_t            cmd,
  output stbs_pkg::dp_status_t           status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic [stbs_pkg::FIELD_W-1:0]   position
);

  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int FW         = stbs_pkg::FIELD_W;
  localparam int SEARCH_MAX = (TABLE_DEPTH - 1 < 255) ? TABLE_DEPTH - 1 : 255;

  // Range is [lo, hip1): hip1 is one past the last position
  logic [FW:0]           lo, hip1, lo_next, hip1_next;
  logic [FW-1:0]         mid, mid_next;
  logic [FW-1:0]         mid_in, hi_sat;
  logic [FW:0]           lo_in, hip1_in;
  logic [FW+1:0]         sum_in, sum_next;
  logic [ENTRY_BITS-1:0] tgt;
  logic [ENTRY_BITS-1:0] rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_ok;

  // Incoming range, high end clipped to the table
  always_comb begin
    hi_sat  = (int'(high_index) > SEARCH_MAX) ? FW'(SEARCH_MAX) : high_index;
    lo_in   = {1'b0, low_index};
    hip1_in = {1'b0, hi_sat} + (FW+1)'(1);
    sum_in  = {1'b0, lo_in} + {1'b0, hip1_in} - (FW+2)'(1);
    mid_in  = sum_in[FW:1];
  end

  // Narrow the range around the current probe
  always_comb begin
    lo_next   = lo;
    hip1_next = hip1;
    if (tgt > rd_data) begin
      lo_next = {1'b0, mid} + (FW+1)'(1);
    end else begin
      hip1_next = {1'b0, mid};
    end
    sum_next = {1'b0, lo_next} + {1'b0, hip1_next} - (FW+2)'(1);
    mid_next = sum_next[FW:1];
  end

  always_comb begin
    status.init_empty = (lo_in >= hip1_in);
    status.hit        = (rd_data == tgt);
    status.next_empty = (lo_next >= hip1_next);
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo   <= lo_in;
      hip1 <= hip1_in;
      mid  <= mid_in;
      tgt  <= ENTRY_BITS'(target);
    end else if (cmd.step) begin
      lo   <= lo_next;
      hip1 <= hip1_next;
      mid  <= mid_next;
    end
  end

  // Probe address follows the midpoint that will be compared next cycle
  always_comb begin
    if (cmd.load) begin
      rd_addr = IDX_W'(mid_in);
    end else if (cmd.step) begin
      rd_addr = IDX_W'(mid_next);
    end else begin
      rd_addr = IDX_W'(mid);
    end
  end

  assign wr_ok = cmd.wr_en && (int'(entry_index) < TABLE_DEPTH);

  stbs_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (IDX_W'(entry_index)),
    .wr_data (ENTRY_BITS'(entry_value)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      found    <= cmd.post_hit;
      position <= cmd.post_hit ? mid : '0;
    end
  end

endmodule

[hw/rtl/sorted_table_binary_search_top.sv]
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_ctrl, stbs_dpath (which holds stbs_ram).
`timescale 1ns / 1ps
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+------------------
//  s_*     | in  | entry_index, entry_value, target,       | cmd (0 write,
//          |     | low_index, high_index (8 bits each)     |      1 search)
//  m_*     | out | position (8 bits)                       | found
//
//  A write word gives no result and leaves the input ready. A search word
//  probes the table once per step, up to nine probes for a 256-entry
//  table; each probe loops through the RAM's registered read, the compare
//  and the midpoint adder. An empty range gives a miss at position zero
//  without a search. Reset clears the controller and the result valid; the
//  table holds whatever it held until written. A stalled result holds the
//  search at its last probe, while the next word waits for the search.
//

module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int ENTRY_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] entry_index, [15:8] entry_value, [23:16] target,
  // [31:24] low_index, [39:32] high_index
  input  logic [39:0] s_tdata,
  // [0] cmd
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] position
  output logic [7:0]  m_tdata,
  // [0] found
  output logic [0:0]  m_tuser
);

  stbs_pkg::ctrl_cmd_t  cmd;
  stbs_pkg::dp_status_t status;

  // Sequence writes and searches; the probe loop runs in the datapath
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .item_cmd (s_tuser[0]),
    .status   (status),
    .cmd      (cmd)
  );

  // Unpack the input word straight into the datapath fields
  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .entry_index (s_tdata[7:0]),
    .entry_value (s_tdata[15:8]),
    .target      (s_tdata[23:16]),
    .low_index   (s_tdata[31:24]),
    .high_index  (s_tdata[39:32]),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .found       (m_tuser[0]),
    .position    (m_tdata)
  );

endmodule

[hw/rtl/stbs_checker.sv]
// Port-level checks for the sorted table binary search block, bound to the top.
// Depends on sorted_table_binary_search_top.
`timescale 1ns / 1ps

module stbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Position is zero on a miss
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("nonzero position on a miss");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A search word blocks the input while it runs
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input ready during a search");

  // A write word leaves the input open
  a_write_open: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
    else $error("input blocked after a write");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[test/stbs_checker.sv]
// Scoreboard for the sorted table binary search block: mirrors the table from
// accepted write words and checks each search result in order.
// Depends on stbs_pkg for the command codes.
`timescale 1ns / 1ps

module stbs_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [7:0] entry_index, [15:8] entry_value, [23:16] target,
  // [31:24] low_index, [39:32] high_index
  input  logic [39:0] s_tdata,
  // [0] cmd
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] position
  input  logic [7:0]  m_tdata,
  // [0] found
  input  logic [0:0]  m_tuser,
  output int          mismatches,
  output int          outstanding
);

  localparam int DEPTH = 256;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic       found;
    logic [7:0] position;
  } lookup_t;

  logic [7:0] entry_mem [DEPTH];
  lookup_t    awaited_q [$];
  int         results_seen = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Halve the inclusive range at the floor midpoint until a hit or an empty range.
  function automatic lookup_t bisect_lookup(logic [7:0] key, logic [7:0] lo_idx,
                                            logic [7:0] hi_idx);
    int      lo;
    int      hi;
    int      mid;
    lookup_t res;
    lo  = int'(lo_idx);
    hi  = int'(hi_idx);
    res = '0;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (entry_mem[mid[7:0]] == key) begin
        res.found    = 1'b1;
        res.position = mid[7:0];
        return res;
      end else if (key > entry_mem[mid[7:0]]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    lookup_t got;
    if (rst) begin
      awaited_q.delete();
      outstanding = 0;
    end else begin
      // retire the result first so that it can never pair with a search
      // accepted in the same cycle
      if (m_tvalid && m_tready) begin
        got.found    = m_tuser[0];
        got.position = m_tdata;
        results_seen++;
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR: result %0d arrived with no search pending: ",
                     results_seen, "found=%0b position=%0d", got.found, got.position);
        end else begin
          want = awaited_q.pop_front();
          if (got.found !== want.found || got.position !== want.position) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("ERROR: result %0d: expected found=%0b position=%0d, ",
                       results_seen, want.found, want.position,
                       "got found=%0b position=%0d", got.found, got.position);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == stbs_pkg::CMD_WRITE) begin
          entry_mem[s_tdata[7:0]] = s_tdata[15:8];
        end else begin
          awaited_q.push_back(bisect_lookup(s_tdata[23:16], s_tdata[31:24],
                                            s_tdata[39:32]));
        end
      end
      outstanding = awaited_q.size();
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top for the sorted table binary search block: drives write and
// search words with random gaps and back-pressure, and reports the verdict.
// Depends on stbs_pkg, sorted_table_binary_search_top and stbs_scoreboard.
`timescale 1ns / 1ps

module tb_top;

  // The longest legal stretch without any accepted word is the long receiver
  // hold plus one search plus a sender gap and a receiver gap; take the limit
  // several times over that.
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TOTAL_WORDS = 525;
  localparam int TAIL_CYCLES = 24;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = stbs_pkg::CMD_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;

  int mismatches;
  int outstanding;

  // Stimulus-side copy of the table, used to pick search keys and to keep searches
  // away from entries that were never written since reset.
  logic [7:0] shadow_mem [256];
  bit         written    [256];

  int words_sent    = 0;
  int idle_cycles   = 0;
  bit sender_burst  = 1'b0;  // forced back-to-back words
  bit sender_steady = 1'b0;  // a stretch of episodes with no sender gaps
  bit stall_armed   = 1'b0;  // ask the receiver for its one long hold

  always #6 clk = ~clk;

  sorted_table_binary_search_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  stbs_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_table_binary_search_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int sender_gap();
    if (sender_burst || sender_steady) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Walk the halving steps over the shadow table; a probe of an unwritten
  // entry makes the search illegal.
  function automatic bit search_path_defined(logic [7:0] key, logic [7:0] lo_idx,
                                             logic [7:0] hi_idx);
    int lo;
    int hi;
    int mid;
    lo = int'(lo_idx);
    hi = int'(hi_idx);
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!written[mid[7:0]]) return 1'b0;
      if (shadow_mem[mid[7:0]] == key) return 1'b1;
      if (key > shadow_mem[mid[7:0]]) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b1;
  endfunction

  // Offer one word and return at the rising edge that accepts it, with
  // tvalid still high. A zero gap keeps tvalid up so the next word follows
  // without a bubble; tready is sampled at the falling edge, clear of the
  // clock edge at which the block updates.
  task automatic offer_word(input logic [0:0] cmd, input logic [39:0] payload);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= payload;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Fields a write does not use carry random bits.
  task automatic send_write(input logic [7:0] idx, input logic [7:0] val);
    logic [23:0] junk;
    junk = 24'($urandom);
    offer_word(stbs_pkg::CMD_WRITE, {junk, val, idx});
    shadow_mem[idx] = val;
    written[idx]    = 1'b1;
  endtask

  task automatic send_search(input logic [7:0] key, input logic [7:0] lo,
                             input logic [7:0] hi);
    logic [15:0] junk;
    junk = 16'($urandom);
    offer_word(stbs_pkg::CMD_SEARCH, {hi, lo, key, junk});
  endtask

  // Lower tvalid and hold until every pending search has returned.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Search an arbitrary range; fall back to an empty range when no legal
  // draw turns up.
  task automatic send_random_search();
    logic [7:0] key;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] swap;
    logic [7:0] pick;
    int         tries;
    tries = 0;
    do begin
      lo  = 8'($urandom);
      hi  = 8'($urandom);
      key = 8'($urandom);
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      if (lo <= hi && $urandom_range(0, 2) != 0) begin
        pick = 8'($urandom_range(lo, hi));
        if (written[pick]) key = shadow_mem[pick];
      end
      tries++;
    end while (!search_path_defined(key, lo, hi) && tries < 16);
    if (!search_path_defined(key, lo, hi)) begin
      lo = 8'($urandom_range(1, 255));
      hi = 8'($urandom_range(0, lo - 1));
    end
    send_search(key, lo, hi);
  endtask

  // Load an ascending run at a random place (written upward or downward)
  // and search inside it, so that searches go through all of their halvings.
  task automatic load_sorted_run();
    int         base;
    int         len;
    int         top;
    int         v;
    int         i;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] swap;
    logic [7:0] key;
    logic [7:0] pick;
    base = $urandom_range(0, 255);
    len  = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
    top  = base + len - 1;
    if (top > 255) top = 255;
    if ($urandom_range(0, 1)) begin
      v = $urandom_range(0, 64);
      for (i = base; i <= top; i++) begin
        v += $urandom_range(0, 12);
        if (v > 255) v = 255;
        send_write(i[7:0], v[7:0]);
      end
    end else begin
      v = $urandom_range(191, 255);
      for (i = top; i >= base; i--) begin
        v -= $urandom_range(0, 12);
        if (v < 0) v = 0;
        send_write(i[7:0], v[7:0]);
      end
    end
    repeat ($urandom_range(2, 8)) begin
      lo = 8'($urandom_range(base, top));
      hi = 8'($urandom_range(base, top));
      // keep a few empty ranges, swap the rest into order
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      pick = (lo <= hi) ? 8'($urandom_range(lo, hi)) : lo;
      case ($urandom_range(0, 3))
        0: key = 8'($urandom);
        1: key = shadow_mem[pick] + 8'd1;
        default: key = shadow_mem[pick];
      endcase
      send_search(key, lo, hi);
    end
  endtask

  // Result side: a random wait before each word, stretches with no waits,
  // and one long hold so that the block backs up into its input.
  initial begin : result_sink
    bit steady;
    bit hold_done;
    int gap;
    int taken;
    steady    = 1'b0;
    hold_done = 1'b0;
    taken     = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (stall_armed && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (taken % 32 == 0 && $urandom_range(0, 1)) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sparse sorted table at the ends and quarter points.
    send_write(8'd0,   8'h00);
    send_write(8'd63,  8'h40);
    send_write(8'd127, 8'h80);
    send_write(8'd191, 8'hC0);
    send_write(8'd255, 8'hFF);
    send_search(8'h80, 8'd0,   8'd255);  // hit at the first midpoint
    send_search(8'h00, 8'd0,   8'd0);    // one-entry range, hit at zero
    send_search(8'hFF, 8'd255, 8'd255);  // one-entry range, hit at the top
    send_search(8'h10, 8'd0,   8'd0);    // low index steps past high, miss above zero
    send_search(8'hFF, 8'd0,   8'd0);    // low index steps past high
    send_search(8'h00, 8'd255, 8'd255);  // miss at the top entry
    send_search(8'h40, 8'd0,   8'd127);  // hit one level down
    send_search(8'hC0, 8'd128, 8'd255);  // hit in the upper half
    send_search(8'h00, 8'd200, 8'd100);  // empty range
    send_search(8'hFF, 8'd255, 8'd0);    // empty range, extreme indexes
    send_write(8'd254, 8'hFE);
    send_search(8'hFF, 8'd254, 8'd255);  // second probe lands on the last entry
    // Unsorted pair: the halving steps miss a value that is present.
    send_write(8'd1, 8'h05);
    send_write(8'd2, 8'h01);
    send_search(8'h05, 8'd1, 8'd2);
    send_search(8'h01, 8'd1, 8'd2);
    // Small value at the top: the low index steps past the last position.
    send_write(8'd255, 8'h7F);
    send_search(8'h90, 8'd255, 8'd255);

    // Hold until the block is empty, then fill it against a stalled receiver.
    drain_results();
    stall_armed  = 1'b1;
    sender_burst = 1'b1;
    repeat (16) send_random_search();
    sender_burst = 1'b0;

    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 3) == 0) sender_steady = !sender_steady;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: load_sorted_run();
        6: repeat ($urandom_range(1, 4)) send_write(8'($urandom), 8'($urandom));
        7, 8: repeat ($urandom_range(1, 6)) send_random_search();
        default: drain_results();
      endcase
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sorted_table_binary_search_top test passed");
    end else begin
      $display("sorted_table_binary_search_top test failed");
    end
    $finish;
  end

endmodule
